@@ src/ipt_pkg.sv @@
// Shared constants, types and helper functions of the inverted page table translator.
package ipt_pkg;

    // Table geometry and tag layout.
    localparam int FRAMES       = 64;
    localparam int FRAME_BITS   = $clog2(FRAMES);
    localparam int FCNT_BITS    = $clog2(FRAMES + 1);
    localparam int PID_BITS     = 8;
    localparam int PAGE_BITS    = 16;
    localparam int OFFSET_BITS  = 12;
    localparam int TAG_BITS     = PID_BITS + PAGE_BITS;
    localparam int OWID_BITS    = $clog2(OFFSET_BITS + 1);

    // Field widths of the words on the channels.
    localparam int FIDX_W       = 6;
    localparam int PID_W        = 8;
    localparam int PAGE_W       = 16;
    localparam int OFF_W        = 12;
    localparam int FNUM_W       = 6;
    localparam int PADDR_W      = 18;

    // Configuration register widths and reset values.
    localparam int NPROC_W      = 9;
    localparam int NPAGE_W      = 17;
    localparam int PSIZE_W      = 13;
    localparam int NFRM_W       = 7;
    localparam int CFG_DATA_W   = 17;
    localparam int CFG_IDX_W    = 2;

    localparam logic [NPROC_W-1:0] NPROC_RST = NPROC_W'(256);
    localparam logic [NPAGE_W-1:0] NPAGE_RST = NPAGE_W'(65536);
    localparam logic [PSIZE_W-1:0] PSIZE_RST = PSIZE_W'(4096);
    localparam logic [NFRM_W-1:0]  NFRM_RST  = NFRM_W'(64);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_PROCESSES = 2'd0,
        CFG_NUM_PAGES     = 2'd1,
        CFG_PAGE_BYTES    = 2'd2,
        CFG_NUM_FRAMES    = 2'd3
    } t_cfg_idx;

    // Operation carried by an input word.
    typedef enum logic {
        ACT_WRITE     = 1'b0,
        ACT_TRANSLATE = 1'b1
    } t_action;

    // Control states of the lookup sequencer.
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } t_state;

    // Offset width: number of bits of (size - 1), saturated at OFFSET_BITS.
    function automatic logic [OWID_BITS-1:0] offset_width(input logic [PSIZE_W-1:0] size);
        logic [PSIZE_W-1:0]   t;
        logic [OWID_BITS-1:0] d;
        t = size - PSIZE_W'(1);
        d = '0;
        for (int i = 0; i < PSIZE_W; i++) begin
            if (t[i]) begin
                d = OWID_BITS'(i + 1);
            end
        end
        if (size == '0) begin
            d = '0;
        end
        if (d > OWID_BITS'(OFFSET_BITS)) begin
            d = OWID_BITS'(OFFSET_BITS);
        end
        return d;
    endfunction

endpackage

@@ src/ipt_in_if.sv @@
// Request channel: carries write and translate words into the translator.
interface ipt_in_if import ipt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [FIDX_W-1:0] frame_index;
    logic [PID_W-1:0]  process_id;
    logic [PAGE_W-1:0] page_number;
    logic [OFF_W-1:0]  page_offset;

    modport source (
        output valid, action, frame_index, process_id, page_number, page_offset,
        input  ready
    );
    modport sink (
        input  valid, action, frame_index, process_id, page_number, page_offset,
        output ready
    );
endinterface

@@ src/ipt_out_if.sv @@
// Response channel: carries translation results out of the translator.
interface ipt_out_if import ipt_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               illegal;
    logic [FNUM_W-1:0]  frame_number;
    logic [PADDR_W-1:0] phys_addr;

    modport source (
        output valid, illegal, frame_number, phys_addr,
        input  ready
    );
    modport sink (
        input  valid, illegal, frame_number, phys_addr,
        output ready
    );
endinterface

@@ src/ipt_ram.sv @@
// Generic simple dual-port RAM with one write port and one registered read port.
module ipt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ src/inverted_page_table_translate.sv @@
// Inverted page table translator: a translate word reads up to min(num_frames,64) tag
// RAM entries, one per cycle, lowest frame first, the tag RAM read port setting the pace,
// and its result word is registered; the scan pauses while the output register still
// holds an untaken word. A new word is taken once the previous translate has handed its
// result to the output register. Reset restores the configuration defaults and clears
// all valid bits; the tag RAM itself is not cleared.
module inverted_page_table_translate import ipt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ipt_in_if.sink                i_req,
    ipt_out_if.source             o_rsp
);
    // Configuration registers.
    logic [NPROC_W-1:0]   r_num_processes;
    logic [NPAGE_W-1:0]   r_num_pages;
    logic [PSIZE_W-1:0]   r_page_bytes;
    logic [NFRM_W-1:0]    r_num_frames;
    logic [OWID_BITS-1:0] r_off_width;

    // Control state.
    t_state               r_state, n_state;
    logic [FCNT_BITS-1:0] r_idx, n_idx;
    logic [FCNT_BITS-1:0] r_limit, n_limit;
    logic                 r_rd_vld, n_rd_vld;
    logic [FRAME_BITS-1:0] r_rd_idx, n_rd_idx;
    logic [FRAMES-1:0]    r_valid;
    logic                 r_out_valid, n_out_valid;

    // Payload registers.
    logic [TAG_BITS-1:0]  r_key, n_key;
    logic [OFF_W-1:0]     r_off, n_off;
    logic                 r_out_illegal, n_out_illegal;
    logic [FNUM_W-1:0]    r_out_frame, n_out_frame;
    logic [PADDR_W-1:0]   r_out_paddr, n_out_paddr;

    // Handshake and memory controls.
    logic                 req_accept;
    logic                 tbl_we;
    logic                 tbl_re;
    logic [TAG_BITS-1:0]  tbl_wdata;
    logic [TAG_BITS-1:0]  tbl_rdata;
    logic                 hit;
    logic                 out_free;
    logic                 lim_fail;
    logic                 finish;
    logic                 finish_found;

    // Tag store, one entry per physical frame.
    ipt_ram #(
        .WIDTH (TAG_BITS),
        .DEPTH (FRAMES)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (i_req.frame_index[FRAME_BITS-1:0]),
        .i_wdata (tbl_wdata),
        .i_re    (tbl_re),
        .i_raddr (r_idx[FRAME_BITS-1:0]),
        .o_rdata (tbl_rdata)
    );

    // Input handshake and table writes.
    assign i_req.ready = (r_state == ST_IDLE);
    assign req_accept  = i_req.valid && i_req.ready;
    assign tbl_wdata   = {i_req.process_id[PID_BITS-1:0], i_req.page_number[PAGE_BITS-1:0]};
    assign tbl_we      = req_accept && (i_req.action == ACT_WRITE)
                         && (32'(i_req.frame_index) < FRAMES);

    // Compare the entry returned by the RAM against the search key.
    assign hit      = r_rd_vld && r_valid[r_rd_idx] && (tbl_rdata == r_key);
    assign out_free = !r_out_valid || o_rsp.ready;

    // Limit checks on the full fields of the pending translate.
    assign lim_fail = ({1'b0, r_key[TAG_BITS-1:PAGE_BITS]} >= r_num_processes)
                      || ({1'b0, r_key[PAGE_BITS-1:0]} >= r_num_pages)
                      || ({1'b0, r_off} >= r_page_bytes);

    // Sequencer: next state, RAM reads and the result word.
    always_comb begin
        n_state       = r_state;
        n_idx         = r_idx;
        n_limit       = r_limit;
        n_rd_vld      = r_rd_vld;
        n_rd_idx      = r_rd_idx;
        n_key         = r_key;
        n_off         = r_off;
        n_out_valid   = r_out_valid;
        n_out_illegal = r_out_illegal;
        n_out_frame   = r_out_frame;
        n_out_paddr   = r_out_paddr;
        tbl_re        = 1'b0;
        finish        = 1'b0;
        finish_found  = 1'b0;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (req_accept && (i_req.action == ACT_TRANSLATE)) begin
                    n_key    = {i_req.process_id[PID_BITS-1:0],
                                i_req.page_number[PAGE_BITS-1:0]};
                    n_off    = i_req.page_offset;
                    n_idx    = '0;
                    n_rd_vld = 1'b0;
                    n_limit  = (32'(r_num_frames) > FRAMES) ? FCNT_BITS'(FRAMES)
                                                            : FCNT_BITS'(r_num_frames);
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (hit) begin
                        finish       = 1'b1;
                        finish_found = 1'b1;
                    end else if (r_idx == r_limit) begin
                        finish = 1'b1;
                    end else begin
                        tbl_re   = 1'b1;
                        n_idx    = r_idx + FCNT_BITS'(1);
                        n_rd_vld = 1'b1;
                        n_rd_idx = r_idx[FRAME_BITS-1:0];
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Load the output register at the end of a lookup.
        if (finish) begin
            n_state     = ST_IDLE;
            n_rd_vld    = 1'b0;
            n_out_valid = 1'b1;
            if (finish_found && !lim_fail) begin
                n_out_illegal = 1'b0;
                n_out_frame   = FNUM_W'(r_rd_idx);
                n_out_paddr   = (PADDR_W'(r_rd_idx) << r_off_width) | PADDR_W'(r_off);
            end else begin
                n_out_illegal = 1'b1;
                n_out_frame   = '0;
                n_out_paddr   = '0;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_limit     <= '0;
            r_rd_vld    <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
            r_valid     <= '0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_limit     <= n_limit;
            r_rd_vld    <= n_rd_vld;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
            if (tbl_we) begin
                r_valid[i_req.frame_index[FRAME_BITS-1:0]] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_key         <= n_key;
        r_off         <= n_off;
        r_out_illegal <= n_out_illegal;
        r_out_frame   <= n_out_frame;
        r_out_paddr   <= n_out_paddr;
    end

    // Configuration registers; the offset width is derived when the page size is written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_processes <= NPROC_RST;
            r_num_pages     <= NPAGE_RST;
            r_page_bytes    <= PSIZE_RST;
            r_num_frames    <= NFRM_RST;
            r_off_width     <= offset_width(PSIZE_RST);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_NUM_PROCESSES: r_num_processes <= i_cfg_data[NPROC_W-1:0];
                CFG_NUM_PAGES:     r_num_pages     <= i_cfg_data[NPAGE_W-1:0];
                CFG_PAGE_BYTES: begin
                    r_page_bytes <= i_cfg_data[PSIZE_W-1:0];
                    r_off_width  <= offset_width(i_cfg_data[PSIZE_W-1:0]);
                end
                CFG_NUM_FRAMES:    r_num_frames    <= i_cfg_data[NFRM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Output channel.
    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.illegal      = r_out_illegal;
    assign o_rsp.frame_number = r_out_frame;
    assign o_rsp.phys_addr    = r_out_paddr;
endmodule

@@ bench/translate_checker.sv @@
`timescale 1ns / 100ps
// Checker that mirrors the frame table, predicts each translation and compares result words.
module translate_checker import ipt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    ipt_in_if                     req,
    ipt_out_if                    rsp,
    output int                    o_mismatches,
    output int                    o_outstanding
);

    // One predicted result word.
    typedef struct packed {
        logic               illegal;
        logic [FNUM_W-1:0]  frame;
        logic [PADDR_W-1:0] paddr;
    } t_xlat;

    // Shadow frame table and limit registers.
    logic [TAG_BITS-1:0] frame_tag [FRAMES];
    logic [FRAMES-1:0]   frame_valid;
    logic [NPROC_W-1:0]  lim_proc;
    logic [NPAGE_W-1:0]  lim_pages;
    logic [PSIZE_W-1:0]  lim_psize;
    logic [NFRM_W-1:0]   lim_frames;

    t_xlat expected_xlats[$];
    t_xlat want;
    int    mismatches = 0;

    // Bits needed to hold an offset below the page size, capped at the offset field.
    function automatic int unsigned offset_bits(logic [PSIZE_W-1:0] size);
        int unsigned d;
        int unsigned span;
        d = 0;
        if (size == '0) begin
            return 0;
        end
        span = size - 1;
        while (span != 0) begin
            d++;
            span >>= 1;
        end
        return (d > OFFSET_BITS) ? OFFSET_BITS : d;
    endfunction

    // Lowest valid matching frame among those searched, then the limit checks.
    function automatic t_xlat translate_word(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                                             logic [OFF_W-1:0] off);
        logic [TAG_BITS-1:0] key;
        int unsigned         reach;
        int unsigned         hit_frame;
        logic                hit;
        t_xlat               r;
        key = {PID_BITS'(pid), PAGE_BITS'(page)};
        reach = (lim_frames > FRAMES) ? FRAMES : lim_frames;
        hit = 1'b0;
        hit_frame = 0;
        for (int f = 0; f < FRAMES; f++) begin
            if (!hit && f < reach && frame_valid[f] && frame_tag[f] == key) begin
                hit = 1'b1;
                hit_frame = f;
            end
        end
        r = '0;
        if (hit && pid < lim_proc && page < lim_pages && off < lim_psize) begin
            r.frame = FNUM_W'(hit_frame);
            r.paddr = PADDR_W'((hit_frame << offset_bits(lim_psize)) | off);
        end else begin
            r.illegal = 1'b1;
        end
        return r;
    endfunction

    // Reports one field of a result word that differs from the prediction.
    function automatic void check_field(string field, int unsigned exp_val, int unsigned got);
        if (exp_val != got) begin
            mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, exp_val, got);
        end
    endfunction

    // Result words are checked before the same edge's request word is predicted,
    // since a result never belongs to a word taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frame_valid = '0;
            lim_proc    = NPROC_RST;
            lim_pages   = NPAGE_RST;
            lim_psize   = PSIZE_RST;
            lim_frames  = NFRM_RST;
            expected_xlats.delete();
        end else begin
            if (rsp.valid && rsp.ready) begin
                if (expected_xlats.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result word, expected none, got %0b/%0d/%0d",
                             $time, rsp.illegal, rsp.frame_number, rsp.phys_addr);
                end else begin
                    want = expected_xlats.pop_front();
                    check_field("illegal", want.illegal, rsp.illegal);
                    check_field("frame_number", want.frame, rsp.frame_number);
                    check_field("phys_addr", want.paddr, rsp.phys_addr);
                end
            end

            if (req.valid && req.ready) begin
                if (t_action'(req.action) == ACT_WRITE) begin
                    if (req.frame_index < FRAMES) begin
                        frame_tag[req.frame_index] =
                            {PID_BITS'(req.process_id), PAGE_BITS'(req.page_number)};
                        frame_valid[req.frame_index] = 1'b1;
                    end
                end else begin
                    expected_xlats.push_back(
                        translate_word(req.process_id, req.page_number, req.page_offset));
                end
            end

            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_NUM_PROCESSES: lim_proc = i_cfg_data[NPROC_W-1:0];
                    CFG_NUM_PAGES:     lim_pages = i_cfg_data[NPAGE_W-1:0];
                    CFG_PAGE_BYTES:    lim_psize = i_cfg_data[PSIZE_W-1:0];
                    CFG_NUM_FRAMES:    lim_frames = i_cfg_data[NFRM_W-1:0];
                    default: ;
                endcase
            end
        end
        o_mismatches  <= mismatches;
        o_outstanding <= expected_xlats.size();
    end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps
// Top of the translator bench: clock, reset, request and limit stimulus, and the verdict.
module testbench import ipt_pkg::*; ();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = FRAMES + 8;
    localparam int POOL         = 16;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int          mismatches;
    int          outstanding;
    int unsigned cycles = 0;
    bit          no_idle;
    int          rsp_stall;
    logic        rsp_taken;

    // Current limits, kept only to aim the random words at legal ranges.
    int unsigned cur_proc;
    int unsigned cur_psize;
    int unsigned cur_pages;
    int unsigned cur_frames;

    // Tags that the random part writes and then looks up.
    logic [PID_W-1:0]  pool_pid  [POOL];
    logic [PAGE_W-1:0] pool_page [POOL];

    ipt_in_if  req_if ();
    ipt_out_if rsp_if ();

    inverted_page_table_translate i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    translate_checker u_translate_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .req           (req_if),
        .rsp           (rsp_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #5 i_clk = ~i_clk;

    // Run limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    // Result side: after each taken word, hold ready low for a drawn number of cycles.
    always @(posedge i_clk) begin
        rsp_taken <= rsp_if.valid && rsp_if.ready;
    end

    always @(negedge i_clk) begin
        if (rsp_taken) begin
            rsp_stall = no_idle ? 0 : $urandom_range(0, 8);
        end
        if (rsp_stall > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_stall--;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Random value below a limit and within a field; the whole field if the limit is zero.
    function automatic int unsigned pick_below(int unsigned limit, int unsigned top);
        if (limit == 0) begin
            return $urandom_range(0, top);
        end
        return $urandom_range(0, (limit - 1 < top) ? limit - 1 : top);
    endfunction

    // Presents one request word after a drawn gap and holds it until taken.
    task automatic push_word(t_action act, logic [FIDX_W-1:0] fidx, logic [PID_W-1:0] pid,
                             logic [PAGE_W-1:0] page, logic [OFF_W-1:0] off);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 8);
        repeat (gap) begin
            @(negedge i_clk);
            req_if.valid = 1'b0;
        end
        @(negedge i_clk);
        req_if.valid       = 1'b1;
        req_if.action      = act;
        req_if.frame_index = fidx;
        req_if.process_id  = pid;
        req_if.page_number = page;
        req_if.page_offset = off;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_entry(logic [FIDX_W-1:0] fidx, logic [PID_W-1:0] pid,
                               logic [PAGE_W-1:0] page);
        push_word(ACT_WRITE, fidx, pid, page, OFF_W'($urandom));
    endtask

    task automatic lookup(logic [PID_W-1:0] pid, logic [PAGE_W-1:0] page,
                          logic [OFF_W-1:0] off);
        push_word(ACT_TRANSLATE, FIDX_W'($urandom), pid, page, off);
    endtask

    // Stops sending and waits until every predicted result word has come.
    task automatic wait_results();
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (outstanding != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, int unsigned value);
        @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
    endtask

    // New limits are written only once the translator has gone idle.
    task automatic set_limits(int unsigned nproc, int unsigned npages, int unsigned psize,
                              int unsigned nframes);
        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(CFG_NUM_PROCESSES, nproc);
        write_reg(CFG_NUM_PAGES, npages);
        write_reg(CFG_PAGE_BYTES, psize);
        write_reg(CFG_NUM_FRAMES, nframes);
        @(negedge i_clk);
        cfg_we     = 1'b0;
        cur_proc   = nproc;
        cur_pages  = npages;
        cur_psize  = psize;
        cur_frames = nframes;
    endtask

    // Mostly writes of pool tags into searched frames and lookups of them,
    // with some fully random words mixed in.
    task automatic run_phase(int count);
        int          kind;
        int unsigned slot;
        logic [OFF_W-1:0] off;
        for (int p = 0; p < POOL; p++) begin
            pool_pid[p]  = PID_W'(pick_below(cur_proc, 255));
            pool_page[p] = PAGE_W'(pick_below(cur_pages, 65535));
        end
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                no_idle = ($urandom_range(0, 3) == 0);
            end
            if (n == count / 2) begin
                wait_results();
            end
            kind = $urandom_range(0, 9);
            slot = $urandom_range(0, POOL - 1);
            off = ($urandom_range(0, 4) == 0) ? OFF_W'($urandom)
                                              : OFF_W'(pick_below(cur_psize, 4095));
            if (kind <= 1) begin
                write_entry(FIDX_W'(pick_below(cur_frames, 63)), pool_pid[slot],
                            pool_page[slot]);
            end else if (kind == 2) begin
                write_entry(FIDX_W'($urandom), pool_pid[slot], pool_page[slot]);
            end else if (kind <= 7) begin
                lookup(pool_pid[slot], pool_page[slot], off);
            end else if (kind == 8) begin
                lookup(PID_W'($urandom), PAGE_W'($urandom), OFF_W'($urandom));
            end else begin
                write_entry(FIDX_W'($urandom), PID_W'($urandom), PAGE_W'($urandom));
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        i_clk              = 1'b0;
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_NUM_PROCESSES;
        cfg_data           = '0;
        req_if.valid       = 1'b0;
        req_if.action      = ACT_WRITE;
        req_if.frame_index = '0;
        req_if.process_id  = '0;
        req_if.page_number = '0;
        req_if.page_offset = '0;
        rsp_if.ready       = 1'b0;
        rsp_stall          = 0;
        no_idle            = 1'b0;
        cur_proc           = NPROC_RST;
        cur_pages          = NPAGE_RST;
        cur_psize          = PSIZE_RST;
        cur_frames         = NFRM_RST;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words at the reset limits.
        lookup(8'd0, 16'd0, 12'd0);                 // empty table: no match
        write_entry(6'd0, 8'd0, 16'd0);
        lookup(8'd0, 16'd0, 12'd0);
        write_entry(6'd63, 8'd255, 16'hFFFF);
        lookup(8'd255, 16'hFFFF, 12'hFFF);           // highest frame, full address
        write_entry(6'd5, 8'd255, 16'hFFFF);         // same tag in a lower frame
        lookup(8'd255, 16'hFFFF, 12'd0);
        lookup(8'd1, 16'd0, 12'd0);
        write_entry(6'd0, 8'd1, 16'd0);              // overwrite replaces the old tag
        lookup(8'd0, 16'd0, 12'd0);
        lookup(8'd1, 16'd0, 12'hFFF);
        write_entry(6'd7, 8'hAA, 16'hAAAA);
        lookup(8'hAA, 16'h5555, 12'hAAA);
        lookup(8'hAA, 16'hAAAA, 12'hAAA);
        write_entry(6'd42, 8'h55, 16'h5555);
        lookup(8'h55, 16'h5555, 12'h555);

        // Limit settings, extremes first, then random ones.
        set_limits(NPROC_RST, NPAGE_RST, PSIZE_RST, NFRM_RST);
        run_phase(150);
        set_limits(511, 131071, 8191, 127);          // counts beyond the table and fields
        lookup(8'd255, 16'hFFFF, 12'hFFF);
        run_phase(150);
        set_limits(1, 1, 1, 1);                      // one-byte pages: zero offset width
        lookup(8'd0, 16'd0, 12'd1);
        run_phase(100);
        set_limits(0, 0, 0, 0);                      // nothing searched, nothing legal
        run_phase(40);
        set_limits(16, 300, 2048, 8);
        lookup(8'd1, 16'd0, 12'd2048);
        run_phase(150);
        set_limits(200, 65535, 100, 33);
        run_phase(150);
        set_limits(256, 65536, 4096, 2);             // stale entries above the search range
        lookup(8'd255, 16'hFFFF, 12'd0);
        run_phase(100);
        for (int r = 0; r < 6; r++) begin
            set_limits($urandom_range(1, 511), $urandom_range(1, 131071),
                       $urandom_range(1, 4096), $urandom_range(1, 127));
            run_phase(140);
        end

        wait_results();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

@@ inverted_page_table_translate.f @@
src/ipt_pkg.sv
src/ipt_in_if.sv
src/ipt_out_if.sv
src/ipt_ram.sv
src/inverted_page_table_translate.sv
bench/translate_checker.sv
bench/testbench.sv
